>>> rtl/crl_pkg.sv
// Shared types, constants and reset table of the color ramp lookup table.
package crl_pkg;

  // Table depth default and fixed field widths
  localparam int MAX_NODES_DEF = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = 17;
  localparam int VAL_W         = 32;
  localparam int COLOR_W       = 24;
  localparam int IDX_OUT_W     = 5;
  localparam int STAT_W        = 3;
  localparam int REQ_W         = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CHAN_W        = 8;

  // Divider widths: the difference carries one bit over the value width, the remainder one more
  localparam int DIFF_W = VAL_W + 1;
  localparam int REM_W  = DIFF_W + 1;
  localparam int SH_W   = POS_FRAC_BITS;
  localparam int STEP_W = $clog2(SH_W + 1);
  localparam int NUM_W  = CHAN_W + POS_W;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_FRAC_BITS;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOOKUP_VAL = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP_POS = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT_VAL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INSERT_POS = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX = 1'd1;

  localparam logic signed [VAL_W-1:0] RST_VALUE_MIN = 32'sd0;
  localparam logic signed [VAL_W-1:0] RST_VALUE_MAX = 32'sd500;

  // Reset ramp positions, k * ONE / 5 rounded
  localparam logic [POS_W-1:0] RST_P1 = POS_W'((1 * (1 << POS_FRAC_BITS) + 2) / 5);
  localparam logic [POS_W-1:0] RST_P2 = POS_W'((2 * (1 << POS_FRAC_BITS) + 2) / 5);
  localparam logic [POS_W-1:0] RST_P3 = POS_W'((3 * (1 << POS_FRAC_BITS) + 2) / 5);
  localparam logic [POS_W-1:0] RST_P4 = POS_W'((4 * (1 << POS_FRAC_BITS) + 2) / 5);

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VAL_W-1:0]   data_value;
    logic [POS_W-1:0]          position;
    logic [COLOR_W-1:0]        new_color;
  } crl_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   out_color;
    logic [IDX_OUT_W-1:0] node_index;
    logic [STAT_W-1:0]    status;
  } crl_rsp_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
  } crl_node_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIFF_W-1:0] den;
    logic [SH_W-1:0]   bits;
    logic [STEP_W-1:0] steps;
  } crl_div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VDIV,
    S_SCAN_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_BSTART,
    S_BDIV,
    S_SHIFT_RD,
    S_SHIFT_WR
  } crl_state_t;

  // Node held by a slot that has not been written since reset
  function automatic crl_node_t reset_node(input logic [7:0] k);
    crl_node_t n;
    case (k)
      8'd0:    n = '{pos: '0,      color: 24'hFF6699};
      8'd1:    n = '{pos: RST_P1,  color: 24'hFF0000};
      8'd2:    n = '{pos: RST_P2,  color: 24'h00FF00};
      8'd3:    n = '{pos: RST_P3,  color: 24'h00FFFF};
      8'd4:    n = '{pos: RST_P4,  color: 24'h0066FF};
      8'd5:    n = '{pos: POS_ONE, color: 24'h0000FF};
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/color_ramp_lookup_table_unit.sv
// Top level of the color ramp lookup table: node memory, request sequencer.
//
// Usage: drive in_req and raise start; the request transfers at a clock edge
// where start is high and busy is low. busy stays high while the request is
// worked on. Exactly one result per request appears on out_rsp for a single
// cycle with out_valid high; it cannot be held off, so capture it then.
// Configuration: cfg_we with cfg_idx selects value_min (0) or value_max (1),
// written from cfg_wdata at that edge; write only while busy is low.
// A lookup by value strictly inside the range, or an insert by value from
// value_min to below value_max, first maps the value to a position in the
// divider. The scan then reads nodes from slot 0; a lookup between two nodes
// blends their colors, an insert of a new node shifts later nodes up and a
// remove shifts them down. Empty table (lookup, remove) or insert position
// above one: result at the scan start; unknown code or insert value out of
// range: result at once. Scan and shifts share the node memory ports, one
// slot at a time (read state, then check or write state); each blend channel
// runs a multiply, a divider start and an 8-step divide, and the value
// mapping a 16-step divide in the shared divider.
// Reset: the table returns to the six-node rainbow at once through per-slot
// valid flags, value_min to 0 and value_max to 500; no clearing pass.
module color_ramp_lookup_table_unit #(
  parameter int MAX_NODES = crl_pkg::MAX_NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  crl_pkg::crl_req_t                 in_req,
  input  logic                              cfg_we,
  input  logic [crl_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [crl_pkg::VAL_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  output crl_pkg::crl_rsp_t                 out_rsp
);
  import crl_pkg::*;

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int IW = $clog2(MAX_NODES);
  localparam logic [CW-1:0] RST_COUNT = CW'((MAX_NODES < 6) ? MAX_NODES : 6);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_NODES);

  // Node memory
  crl_node_t             mem [MAX_NODES];
  logic [MAX_NODES-1:0]  valid_r;
  crl_node_t             rd_q;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_idx_q;
  crl_node_t             rd_node;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  crl_node_t             wr_data;

  // Control and request state
  crl_state_t              state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           j_r, j_nxt;
  logic [CW-1:0]           jm1, jp1, cm1;
  logic [REQ_W-1:0]        req_r, req_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [COLOR_W-1:0]      color_r, color_nxt;
  logic [POS_W-1:0]        prev_pos_r, prev_pos_nxt;
  logic [COLOR_W-1:0]      prev_col_r, prev_col_nxt;
  logic [COLOR_W-1:0]      bl_a_r, bl_a_nxt;
  logic [COLOR_W-1:0]      bl_b_r, bl_b_nxt;
  logic [POS_W-1:0]        t_r, t_nxt;
  logic [POS_W-1:0]        d_r, d_nxt;
  logic [1:0]              chan_r, chan_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [COLOR_W-1:0]      res_col_r, res_col_nxt;
  logic                    out_valid_r, out_valid_nxt;
  crl_rsp_t                out_rsp_r, out_rsp_nxt;
  logic signed [VAL_W-1:0] vmin_r, vmax_r;

  // Divider hookup
  logic          div_start;
  crl_div_req_t  div_req;
  logic          div_done;
  logic [SH_W-1:0] div_quo;

  // Value range helpers
  logic signed [DIFF_W-1:0] vdiff, vden;
  logic v_le_min, v_lt_min, v_ge_max, v_gt_max, v_eq_max, range_bad;
  logic is_lookup, is_insert, is_remove;
  logic [CHAN_W-1:0] ch_s, ch_e;

  crl_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign vdiff = DIFF_W'($signed(in_req.data_value)) - DIFF_W'(vmin_r);
  assign vden  = DIFF_W'(vmax_r) - DIFF_W'(vmin_r);
  assign v_le_min  = $signed(in_req.data_value) <= vmin_r;
  assign v_lt_min  = $signed(in_req.data_value) <  vmin_r;
  assign v_ge_max  = $signed(in_req.data_value) >= vmax_r;
  assign v_gt_max  = $signed(in_req.data_value) >  vmax_r;
  assign v_eq_max  = $signed(in_req.data_value) == vmax_r;
  assign range_bad = vmax_r <= vmin_r;

  assign is_lookup = (req_r == REQ_LOOKUP_VAL) || (req_r == REQ_LOOKUP_POS);
  assign is_insert = (req_r == REQ_INSERT_VAL) || (req_r == REQ_INSERT_POS);
  assign is_remove = (req_r == REQ_REMOVE);

  assign jm1 = j_r - 1'b1;
  assign jp1 = j_r + 1'b1;
  assign cm1 = cnt_r - 1'b1;

  // Unwritten slots read as the reset ramp
  assign rd_node = rd_vld_q ? rd_q : reset_node(8'(rd_idx_q));

  // Pick the channel being blended
  always_comb begin
    case (chan_r)
      2'd0:    begin ch_s = bl_a_r[7:0];   ch_e = bl_b_r[7:0];   end
      2'd1:    begin ch_s = bl_a_r[15:8];  ch_e = bl_b_r[15:8];  end
      default: begin ch_s = bl_a_r[23:16]; ch_e = bl_b_r[23:16]; end
    endcase
  end

  // Request sequencer: next state, memory accesses and result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    req_nxt       = req_r;
    pos_nxt       = pos_r;
    color_nxt     = color_r;
    prev_pos_nxt  = prev_pos_r;
    prev_col_nxt  = prev_col_r;
    bl_a_nxt      = bl_a_r;
    bl_b_nxt      = bl_b_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    chan_nxt      = chan_r;
    num_nxt       = num_r;
    res_col_nxt   = res_col_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    rd_addr       = idx_r[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = j_r[IW-1:0];
    wr_data       = rd_node;
    div_start     = 1'b0;
    div_req.rem   = REM_W'(vdiff);
    div_req.den   = vden;
    div_req.bits  = '0;
    div_req.steps = STEP_W'(SH_W);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req.req_type;
          pos_nxt   = in_req.position;
          color_nxt = in_req.new_color;
          state_nxt = S_SCAN_START;
          case (in_req.req_type)
            REQ_LOOKUP_VAL: begin
              if (v_le_min) begin
                pos_nxt = '0;
              end else if (v_ge_max) begin
                pos_nxt = POS_ONE;
              end else begin
                div_start = 1'b1;
                state_nxt = S_VDIV;
              end
            end
            REQ_INSERT_VAL: begin
              if (range_bad || v_lt_min || v_gt_max) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt   = '{out_color: '0, node_index: '0, status: STAT_RANGE};
                state_nxt     = S_IDLE;
              end else if (v_eq_max) begin
                pos_nxt = POS_ONE;
              end else begin
                div_start = 1'b1;
                state_nxt = S_VDIV;
              end
            end
            REQ_LOOKUP_POS, REQ_INSERT_POS, REQ_REMOVE: begin
              pos_nxt = in_req.position;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{out_color: '0, node_index: '0, status: STAT_RANGE};
              state_nxt     = S_IDLE;
            end
          endcase
        end
      end

      S_VDIV: begin
        if (div_done) begin
          pos_nxt   = POS_W'(div_quo);
          state_nxt = S_SCAN_START;
        end
      end

      S_SCAN_START: begin
        idx_nxt   = '0;
        state_nxt = S_SCAN_RD;
        if ((is_lookup || is_remove) && cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{out_color: '0, node_index: '0, status: STAT_EMPTY};
          state_nxt     = S_IDLE;
        end else if (is_insert && pos_r > POS_ONE) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{out_color: '0, node_index: '0, status: STAT_RANGE};
          state_nxt     = S_IDLE;
        end else if (is_lookup && pos_r > POS_ONE) begin
          pos_nxt = POS_ONE;
        end
      end

      S_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          // Ran past the last node
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (is_lookup) begin
            out_rsp_nxt = '{out_color: prev_col_r, node_index: '0, status: STAT_OK};
          end else if (is_insert) begin
            if (cnt_r >= FULL_COUNT) begin
              out_rsp_nxt = '{out_color: '0, node_index: '0, status: STAT_FULL};
            end else begin
              out_valid_nxt = 1'b0;
              j_nxt         = cnt_r;
              state_nxt     = S_SHIFT_RD;
            end
          end else begin
            out_rsp_nxt = '{out_color: '0, node_index: '0, status: STAT_NOT_FOUND};
          end
        end else begin
          rd_addr   = idx_r[IW-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        prev_pos_nxt = rd_node.pos;
        prev_col_nxt = rd_node.color;
        idx_nxt      = idx_r + 1'b1;
        state_nxt    = S_SCAN_RD;
        if (is_lookup) begin
          if ((idx_r == '0 && pos_r <= rd_node.pos) || pos_r == rd_node.pos) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{out_color: rd_node.color, node_index: '0, status: STAT_OK};
            state_nxt     = S_IDLE;
          end else if (pos_r < rd_node.pos) begin
            if (rd_node.pos == prev_pos_r || pos_r < prev_pos_r) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{out_color: rd_node.color, node_index: '0, status: STAT_OK};
              state_nxt     = S_IDLE;
            end else begin
              bl_a_nxt  = prev_col_r;
              bl_b_nxt  = rd_node.color;
              t_nxt     = pos_r - prev_pos_r;
              d_nxt     = rd_node.pos - prev_pos_r;
              chan_nxt  = '0;
              state_nxt = S_MUL;
            end
          end
        end else if (is_insert) begin
          if (pos_r == rd_node.pos) begin
            // Update the color of an existing node
            wr_en         = 1'b1;
            wr_addr       = idx_r[IW-1:0];
            wr_data       = '{pos: pos_r, color: color_r};
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{out_color: '0, node_index: IDX_OUT_W'(idx_r), status: STAT_OK};
            state_nxt     = S_IDLE;
          end else if (pos_r < rd_node.pos) begin
            idx_nxt = idx_r;
            if (cnt_r >= FULL_COUNT) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{out_color: '0, node_index: '0, status: STAT_FULL};
              state_nxt     = S_IDLE;
            end else begin
              j_nxt     = cnt_r;
              state_nxt = S_SHIFT_RD;
            end
          end
        end else if (pos_r == rd_node.pos) begin
          idx_nxt   = idx_r;
          j_nxt     = idx_r;
          state_nxt = S_SHIFT_RD;
        end
      end

      S_SHIFT_RD: begin
        if (is_insert) begin
          if (j_r > idx_r) begin
            rd_addr   = jm1[IW-1:0];
            state_nxt = S_SHIFT_WR;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = idx_r[IW-1:0];
            wr_data       = '{pos: pos_r, color: color_r};
            cnt_nxt       = cnt_r + 1'b1;
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{out_color: '0, node_index: IDX_OUT_W'(idx_r), status: STAT_OK};
            state_nxt     = S_IDLE;
          end
        end else begin
          if (jp1 < cnt_r) begin
            rd_addr   = jp1[IW-1:0];
            state_nxt = S_SHIFT_WR;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = cm1[IW-1:0];
            wr_data       = '0;
            cnt_nxt       = cm1;
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{out_color: '0, node_index: IDX_OUT_W'(idx_r), status: STAT_OK};
            state_nxt     = S_IDLE;
          end
        end
      end

      S_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = j_r[IW-1:0];
        wr_data   = rd_node;
        j_nxt     = is_insert ? jm1 : jp1;
        state_nxt = S_SHIFT_RD;
      end

      S_MUL: begin
        num_nxt   = NUM_W'(ch_s) * NUM_W'(d_r - t_r) + NUM_W'(ch_e) * NUM_W'(t_r);
        state_nxt = S_BSTART;
      end

      S_BSTART: begin
        div_start     = 1'b1;
        div_req.rem   = REM_W'(num_r >> CHAN_W);
        div_req.den   = DIFF_W'(d_r);
        div_req.bits  = SH_W'(num_r[CHAN_W-1:0]) << (SH_W - CHAN_W);
        div_req.steps = STEP_W'(CHAN_W);
        state_nxt     = S_BDIV;
      end

      S_BDIV: begin
        if (div_done) begin
          case (chan_r)
            2'd0:    res_col_nxt[7:0]   = div_quo[CHAN_W-1:0];
            2'd1:    res_col_nxt[15:8]  = div_quo[CHAN_W-1:0];
            default: res_col_nxt[23:16] = div_quo[CHAN_W-1:0];
          endcase
          if (chan_r == 2'd2) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{out_color: res_col_nxt, node_index: '0, status: STAT_OK};
            state_nxt     = S_IDLE;
          end else begin
            chan_nxt  = chan_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers, configuration and valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= RST_COUNT;
      out_valid_r <= 1'b0;
      vmin_r      <= RST_VALUE_MIN;
      vmax_r      <= RST_VALUE_MAX;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_VALUE_MIN: vmin_r <= $signed(cfg_wdata);
          REG_VALUE_MAX: vmax_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    j_r        <= j_nxt;
    req_r      <= req_nxt;
    pos_r      <= pos_nxt;
    color_r    <= color_nxt;
    prev_pos_r <= prev_pos_nxt;
    prev_col_r <= prev_col_nxt;
    bl_a_r     <= bl_a_nxt;
    bl_b_r     <= bl_b_nxt;
    t_r        <= t_nxt;
    d_r        <= d_nxt;
    chan_r     <= chan_nxt;
    num_r      <= num_nxt;
    res_col_r  <= res_col_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  // Node memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    rd_vld_q <= valid_r[rd_addr];
    rd_idx_q <= rd_addr;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

>>> rtl/crl_divider.sv
// Shift-subtract divider, one quotient bit per cycle.
module crl_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  crl_pkg::crl_div_req_t     req,
  output logic                      done,
  output logic [crl_pkg::SH_W-1:0]  quo
);
  import crl_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_nxt;
  logic [DIFF_W-1:0] den_r;
  logic [SH_W-1:0]   sh_r;
  logic [SH_W-1:0]   quo_r;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r[REM_W-2:0], sh_r[SH_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  // Step counter and completion strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= req.steps;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= req.rem;
      den_r <= req.den;
      sh_r  <= req.bits;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[SH_W-2:0], 1'b0};
      quo_r <= {quo_r[SH_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/crl_checker.sv
// Port-level checks of the color ramp lookup table, bound to the top level.
module crl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input crl_pkg::crl_rsp_t out_rsp
);
  import crl_pkg::*;

  // A transfer either finishes at once or keeps the block busy
  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy ^ out_valid))
    else $error("request neither started work nor produced a result");

  // A result is shown only once the block is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // Leaving busy always delivers a result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("work ended without a result");

  // Failed requests carry no slot and no color
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != STAT_OK) |->
      (out_rsp.node_index == '0 && out_rsp.out_color == '0))
    else $error("error result with payload");

endmodule

bind color_ramp_lookup_table_unit crl_checker u_crl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
